@@ design/aap_pkg.sv @@
// Package for the address access profiler: sizes, codes, record types and
// the saturating increment used by the sequencer.
// Depends on nothing.
`default_nettype none

package aap_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int RANK_DEPTH  = 16;

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int RANK_W  = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;
  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = CNT_W + 1;
  localparam int RANK_FIELD_W = 5;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [SLOT_W-1:0] HASH_LO = HASH_MULT[SLOT_W-1:0];
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [RANK_W-1:0] rank_idx_t;
  typedef logic [RANK_W:0]   rank_cnt_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  reads;
    logic [CNT_W-1:0]  writes;
  } slot_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   reads;
    logic [CNT_W-1:0]   writes;
    logic [TOTAL_W-1:0] total;
  } rank_entry_t;

  typedef struct packed {
    logic      clear;
    logic      insert;
    rank_idx_t idx;
  } rank_ctl_t;

  typedef struct packed {
    logic                    entry_valid;
    logic [RANK_FIELD_W-1:0] rank;
    logic [ADDR_W-1:0]       entry_address;
    logic [CNT_W-1:0]        read_count;
    logic [CNT_W-1:0]        write_count;
    logic [TOTAL_W-1:0]      total_count;
    logic [CNT_W-1:0]        overflow_count;
    logic                    last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RANK_CMP,
    ST_EMIT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ design/aap_if.sv @@
// Valid/ready channel interfaces for the profiler's command and result streams.
// Depends on aap_pkg for field widths.
`default_nettype none

interface aap_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [aap_pkg::ADDR_W-1:0] access_address;
  logic                      is_write;

  modport source(output valid, output command, output access_address, output is_write,
                 input ready);
  modport sink(input valid, input command, input access_address, input is_write,
               output ready);
endinterface

interface aap_out_if;
  logic                             valid;
  logic                             ready;
  logic                             entry_valid;
  logic [aap_pkg::RANK_FIELD_W-1:0] rank;
  logic [aap_pkg::ADDR_W-1:0]       entry_address;
  logic [aap_pkg::CNT_W-1:0]        read_count;
  logic [aap_pkg::CNT_W-1:0]        write_count;
  logic [aap_pkg::TOTAL_W-1:0]      total_count;
  logic [aap_pkg::CNT_W-1:0]        overflow_count;
  logic                             last;

  modport source(output valid, output entry_valid, output rank, output entry_address,
                 output read_count, output write_count, output total_count,
                 output overflow_count, output last, input ready);
  modport sink(input valid, input entry_valid, input rank, input entry_address,
               input read_count, input write_count, input total_count,
               input overflow_count, input last, output ready);
endinterface

`default_nettype wire

@@ design/aap_slot_mem.sv @@
// Slot table: one memory of address and counts with a registered read port,
// plus an occupied flag per slot that reset clears. Depends on aap_pkg.
`default_nettype none

module aap_slot_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aap_pkg::slot_idx_t   rd_addr,
  output aap_pkg::slot_entry_t rd_data,
  output logic                 rd_occ,
  input  logic                 wr_en,
  input  aap_pkg::slot_idx_t   wr_addr,
  input  aap_pkg::slot_entry_t wr_data
);
  import aap_pkg::*;

  slot_entry_t            mem [TABLE_SLOTS];
  slot_entry_t            rd_data_r;
  logic [TABLE_SLOTS-1:0] occ_r;
  logic                   rd_occ_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      rd_occ_r <= 1'b0;
    end else begin
      if (wr_en) begin
        occ_r[wr_addr] <= 1'b1;
      end
      rd_occ_r <= occ_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign rd_occ  = rd_occ_r;

endmodule

`default_nettype wire

@@ design/aap_rank_list.sv @@
// Sorted list of the best entries with one shared rank comparator and
// insert-with-shift. Depends on aap_pkg.
`default_nettype none

module aap_rank_list (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aap_pkg::rank_ctl_t   ctl,
  input  aap_pkg::rank_entry_t cand,
  output aap_pkg::rank_entry_t entry,
  output logic                 ahead,
  output aap_pkg::rank_cnt_t   used
);
  import aap_pkg::*;

  rank_entry_t list_r [RANK_DEPTH];
  rank_cnt_t   used_r;

  assign entry = list_r[ctl.idx];
  assign ahead = (cand.total > entry.total) ||
                 ((cand.total == entry.total) && (cand.addr < entry.addr));
  assign used  = used_r;

  for (genvar g = 0; g < RANK_DEPTH; g++) begin : g_slot
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ctl.insert && ctl.idx == rank_idx_t'(0)) begin
          list_r[0] <= cand;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (ctl.insert) begin
          if (ctl.idx == rank_idx_t'(g)) begin
            list_r[g] <= cand;
          end else if (ctl.idx < rank_idx_t'(g)) begin
            list_r[g] <= list_r[g-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctl.clear) begin
      used_r <= '0;
    end else if (ctl.insert && used_r != rank_cnt_t'(RANK_DEPTH)) begin
      used_r <= used_r + rank_cnt_t'(1);
    end
  end

endmodule

`default_nettype wire

@@ design/address_access_profiler_unit.sv @@
// Top level of the address access profiler: command sequencer, hash, counters
// and result register. Depends on aap_pkg, aap_if, aap_slot_mem, aap_rank_list.
//
// A record command is accepted, then probes the single-port slot memory, each
// probe a read then a check, from the hashed slot on until it finds its address
// or a free slot; after 256 probes with neither it counts as lost. A report
// command sweeps all 256 slots and compares every occupied slot with the rank
// list (up to 16 compares per slot, one shared comparator), then hands out one
// result per transfer. The block takes no command while either is running.
`default_nettype none

module address_access_profiler_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  aap_in_if.sink                 in_ch,
  aap_out_if.source              out_ch
);
  import aap_pkg::*;

  state_t            state_r, state_nxt;
  logic              profile_enable_r;
  logic [CNT_W-1:0]  lost_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic              req_wr_r;
  slot_idx_t         probe_slot_r;
  slot_idx_t         probe_cnt_r;
  slot_idx_t         scan_idx_r;
  rank_idx_t         rank_idx_r;
  rank_idx_t         emit_idx_r;
  rank_entry_t       cand_r;
  result_t           out_r;
  logic              out_valid_r;

  slot_idx_t         hash_slot;
  slot_idx_t         mem_rd_addr;
  slot_entry_t       mem_rd_data;
  logic              mem_occ;
  logic              mem_wr_en;
  slot_entry_t       mem_wr_data;
  rank_ctl_t         rank_ctl;
  rank_entry_t       rank_entry;
  logic              rank_ahead;
  rank_cnt_t         rank_used;

  logic              in_fire;
  logic              probe_hit;
  logic              probe_last;
  logic              scan_last;
  logic              rank_insert;
  logic              rank_done;
  logic              out_load;
  logic              emit_last;
  logic [CNT_W-1:0]  base_reads;
  logic [CNT_W-1:0]  base_writes;

  aap_slot_mem u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .rd_occ  (mem_occ),
    .wr_en   (mem_wr_en),
    .wr_addr (probe_slot_r),
    .wr_data (mem_wr_data)
  );

  aap_rank_list u_rank_list (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rank_ctl),
    .cand  (cand_r),
    .entry (rank_entry),
    .ahead (rank_ahead),
    .used  (rank_used)
  );

  assign hash_slot   = SLOT_W'(in_ch.access_address[2 +: SLOT_W] * HASH_LO);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign probe_hit   = !mem_occ || (mem_rd_data.addr == req_addr_r);
  assign probe_last  = probe_cnt_r == slot_idx_t'(TABLE_SLOTS - 1);
  assign scan_last   = scan_idx_r == slot_idx_t'(TABLE_SLOTS - 1);
  assign rank_insert = ({1'b0, rank_idx_r} >= rank_used) || rank_ahead;
  assign rank_done   = rank_insert || (rank_idx_r == rank_idx_t'(RANK_DEPTH - 1));
  assign out_load    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign emit_last   = (rank_used == '0) ||
                       (({1'b0, emit_idx_r} + rank_cnt_t'(1)) == rank_used);
  assign base_reads  = mem_occ ? mem_rd_data.reads : '0;
  assign base_writes = mem_occ ? mem_rd_data.writes : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == CMD_REPORT) begin
            state_nxt = ST_SCAN_RD;
          end else if (profile_enable_r) begin
            state_nxt = ST_PROBE_RD;
          end
        end
      end
      ST_PROBE_RD: begin
        state_nxt = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (probe_hit || probe_last) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE_RD;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (mem_occ) begin
          state_nxt = ST_RANK_CMP;
        end else if (scan_last) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_RANK_CMP: begin
        if (rank_done) begin
          state_nxt = scan_last ? ST_EMIT : ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        if (out_load && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready        = (state_r == ST_IDLE);
    mem_rd_addr        = (state_r == ST_SCAN_RD) ? scan_idx_r : probe_slot_r;
    mem_wr_en          = (state_r == ST_PROBE_CHK) && probe_hit;
    mem_wr_data.addr   = req_addr_r;
    mem_wr_data.reads  = req_wr_r ? base_reads : sat_inc(base_reads);
    mem_wr_data.writes = req_wr_r ? sat_inc(base_writes) : base_writes;
    rank_ctl.clear     = in_fire && (in_ch.command == CMD_REPORT);
    rank_ctl.insert    = (state_r == ST_RANK_CMP) && rank_insert;
    rank_ctl.idx       = (state_r == ST_EMIT) ? emit_idx_r : rank_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      profile_enable_r <= 1'b0;
      lost_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        profile_enable_r <= cfg_wr_data;
      end
      if (state_r == ST_PROBE_CHK && !probe_hit && probe_last) begin
        lost_r <= sat_inc(lost_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_addr_r   <= in_ch.access_address;
          req_wr_r     <= in_ch.is_write;
          probe_slot_r <= hash_slot;
          probe_cnt_r  <= '0;
          scan_idx_r   <= '0;
          emit_idx_r   <= '0;
        end
      end
      ST_PROBE_CHK: begin
        if (!probe_hit) begin
          probe_slot_r <= probe_slot_r + slot_idx_t'(1);
          probe_cnt_r  <= probe_cnt_r + slot_idx_t'(1);
        end
      end
      ST_SCAN_CHK: begin
        if (mem_occ) begin
          cand_r.addr   <= mem_rd_data.addr;
          cand_r.reads  <= mem_rd_data.reads;
          cand_r.writes <= mem_rd_data.writes;
          cand_r.total  <= TOTAL_W'(mem_rd_data.reads) + TOTAL_W'(mem_rd_data.writes);
          rank_idx_r    <= '0;
        end else if (!scan_last) begin
          scan_idx_r <= scan_idx_r + slot_idx_t'(1);
        end
      end
      ST_RANK_CMP: begin
        if (!rank_done) begin
          rank_idx_r <= rank_idx_r + rank_idx_t'(1);
        end else if (!scan_last) begin
          scan_idx_r <= scan_idx_r + slot_idx_t'(1);
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_r.overflow_count <= lost_r;
          out_r.last           <= emit_last;
          if (rank_used == '0) begin
            out_r.entry_valid   <= 1'b0;
            out_r.rank          <= '0;
            out_r.entry_address <= '0;
            out_r.read_count    <= '0;
            out_r.write_count   <= '0;
            out_r.total_count   <= '0;
          end else begin
            out_r.entry_valid   <= 1'b1;
            out_r.rank          <= RANK_FIELD_W'({1'b0, emit_idx_r} + rank_cnt_t'(1));
            out_r.entry_address <= rank_entry.addr;
            out_r.read_count    <= rank_entry.reads;
            out_r.write_count   <= rank_entry.writes;
            out_r.total_count   <= rank_entry.total;
          end
          emit_idx_r <= emit_idx_r + rank_idx_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.entry_valid    = out_r.entry_valid;
  assign out_ch.rank           = out_r.rank;
  assign out_ch.entry_address  = out_r.entry_address;
  assign out_ch.read_count     = out_r.read_count;
  assign out_ch.write_count    = out_r.write_count;
  assign out_ch.total_count    = out_r.total_count;
  assign out_ch.overflow_count = out_r.overflow_count;
  assign out_ch.last           = out_r.last;

endmodule

`default_nettype wire

@@ design/aap_checker.sv @@
// Port-level checks for the address access profiler, bound to the top level.
// Depends on aap_pkg for field widths.
`default_nettype none

module aap_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_command,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_entry_valid,
  input logic [aap_pkg::RANK_FIELD_W-1:0] out_rank,
  input logic [aap_pkg::CNT_W-1:0]        out_read_count,
  input logic [aap_pkg::CNT_W-1:0]        out_write_count,
  input logic [aap_pkg::TOTAL_W-1:0]      out_total_count,
  input logic                             out_last
);
  import aap_pkg::*;

  // A stalled result holds its contents until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank) &&
      $stable(out_total_count) && $stable(out_last) && $stable(out_entry_valid))
    else $error("result changed while stalled");

  // The empty-table result is the only one without an entry and ends the report.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last && out_rank == '0)
    else $error("invalid result not marked last with rank zero");

  // A ranked entry has a rank from one and a total equal to its two counts.
  a_entry_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_rank != '0 &&
      out_total_count == (TOTAL_W'(out_read_count) + TOTAL_W'(out_write_count)))
    else $error("ranked entry with bad rank or total");

  // A report keeps the input side closed on the following cycle.
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_REPORT |=> !in_ready)
    else $error("input ready right after a report transfer");

endmodule

bind address_access_profiler_unit aap_checker u_aap_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_entry_valid (out_ch.entry_valid),
  .out_rank        (out_ch.rank),
  .out_read_count  (out_ch.read_count),
  .out_write_count (out_ch.write_count),
  .out_total_count (out_ch.total_count),
  .out_last        (out_ch.last)
);

`default_nettype wire
